>>> rtl/core/assert_macros.svh
// Assertion macros shared by the register file RTL.
// Each macro samples on the rising edge of clock and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds on every clock edge.
`define VM_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Checks that an expression holds in the cycle after a condition.
`define VM_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

>>> rtl/core/vmblk_pkg.sv
// Types, constants and register offsets of the virtio-mmio block register file.
// Used by every module in rtl/core; depends on nothing else.
package vmblk_pkg;

   // Transaction modes on the request channel.
   localparam logic [1:0] MODE_READ     = 2'd0;
   localparam logic [1:0] MODE_WRITE    = 2'd1;
   localparam logic [1:0] MODE_COMPLETE = 2'd2;

   // Fixed register values.
   localparam logic [31:0] MAGIC_VALUE    = 32'h7472_6976;
   localparam logic [31:0] VERSION_VALUE  = 32'd2;
   localparam logic [31:0] DEVICE_ID_BLK  = 32'd2;
   localparam logic [31:0] VENDOR_VALUE   = 32'h0000_1af4;
   localparam logic [63:0] FEAT_VERSION1  = 64'h0000_0001_0000_0000;
   localparam logic [63:0] FEAT_BLK_SIZE  = 64'h0000_0000_0000_0040;
   localparam logic [63:0] FEAT_RO        = 64'h0000_0000_0000_0020;
   localparam int          STATUS_FEAT_OK_BIT = 3;
   localparam logic [15:0] SECTOR_BYTES   = 16'd512;
   localparam logic [8:0]  CFG_SPACE_BYTES = 9'd32;
   localparam logic [15:0] MAX_QUEUE_RESET = 16'd256;

   // Register offsets below the config space.
   localparam logic [7:0] OFS_MAGIC          = 8'h00;
   localparam logic [7:0] OFS_VERSION        = 8'h04;
   localparam logic [7:0] OFS_DEVICE_ID      = 8'h08;
   localparam logic [7:0] OFS_VENDOR         = 8'h0c;
   localparam logic [7:0] OFS_HOST_FEAT      = 8'h10;
   localparam logic [7:0] OFS_HOST_FEAT_SEL  = 8'h14;
   localparam logic [7:0] OFS_GUEST_FEAT     = 8'h20;
   localparam logic [7:0] OFS_GUEST_FEAT_SEL = 8'h24;
   localparam logic [7:0] OFS_PAGE_SIZE      = 8'h28;
   localparam logic [7:0] OFS_QUEUE_SEL      = 8'h30;
   localparam logic [7:0] OFS_QUEUE_NUM_MAX  = 8'h34;
   localparam logic [7:0] OFS_QUEUE_NUM      = 8'h38;
   localparam logic [7:0] OFS_QUEUE_ALIGN    = 8'h3c;
   localparam logic [7:0] OFS_QUEUE_READY    = 8'h44;
   localparam logic [7:0] OFS_QUEUE_NOTIFY   = 8'h50;
   localparam logic [7:0] OFS_INT_STATUS     = 8'h60;
   localparam logic [7:0] OFS_INT_ACK        = 8'h64;
   localparam logic [7:0] OFS_STATUS         = 8'h70;
   localparam logic [7:0] OFS_DESC_LO        = 8'h80;
   localparam logic [7:0] OFS_DESC_HI        = 8'h84;
   localparam logic [7:0] OFS_AVAIL_LO       = 8'h90;
   localparam logic [7:0] OFS_AVAIL_HI       = 8'h94;
   localparam logic [7:0] OFS_USED_LO        = 8'ha0;
   localparam logic [7:0] OFS_USED_HI        = 8'ha4;

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration port.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [1:0] {
      CSR_DEVICE_PRESENT = 2'd0,
      CSR_READ_ONLY      = 2'd1,
      CSR_CAPACITY       = 2'd2,
      CSR_MAX_QUEUE      = 2'd3
   } vmblk_csr_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_REG_READ,
      OP_CFG_READ,
      OP_REG_WRITE,
      OP_COMPLETE
   } vmblk_op_type;

   typedef enum logic [4:0] {
      REG_NONE,
      REG_MAGIC,
      REG_VERSION,
      REG_DEVICE_ID,
      REG_VENDOR,
      REG_HOST_FEAT,
      REG_HOST_FEAT_SEL,
      REG_GUEST_FEAT,
      REG_GUEST_FEAT_SEL,
      REG_PAGE_SIZE,
      REG_QUEUE_SEL,
      REG_QUEUE_NUM_MAX,
      REG_QUEUE_NUM,
      REG_QUEUE_ALIGN,
      REG_QUEUE_READY,
      REG_QUEUE_NOTIFY,
      REG_INT_STATUS,
      REG_INT_ACK,
      REG_STATUS,
      REG_DESC_LO,
      REG_DESC_HI,
      REG_AVAIL_LO,
      REG_AVAIL_HI,
      REG_USED_LO,
      REG_USED_HI
   } vmblk_reg_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [8:0]  address;
      logic [31:0] write_data;
      logic [3:0]  access_bytes;
      logic        suppress_interrupt;
   } vmblk_req_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic        queue_start;
      logic        irq_trigger;
      logic        irq_pending;
      logic [63:0] desc_address;
      logic [63:0] avail_address;
      logic [63:0] used_address;
      logic [15:0] queue_size;
   } vmblk_rsp_type;

   // Classified transaction as it waits in the command queue.
   typedef struct packed {
      vmblk_op_type  op;
      vmblk_reg_type reg_id;
      logic [31:0]   data;
      logic [7:0]    byte_en;
      logic [4:0]    cfg_offset;
   } vmblk_cmd_type;

   // Head of the command queue as seen by the back end.
   typedef struct packed {
      logic          not_empty;
      vmblk_cmd_type head;
   } vmblk_qstat_type;

   // Configuration registers as seen by the back end.
   typedef struct packed {
      logic        device_present;
      logic        read_only;
      logic [54:0] capacity_sectors;
      logic [15:0] max_queue_size;
   } vmblk_cfg_type;

endpackage

>>> rtl/core/vmblk_front.sv
// Front end: accepts request transactions and classifies them into commands.
// Depends on vmblk_pkg; feeds vmblk_queue.
module vmblk_front
   import vmblk_pkg::*;
(
   input  logic          req_valid,
   output logic          req_ready,
   input  vmblk_req_type req_payload,
   input  logic          queue_full,
   output logic          push,
   output vmblk_cmd_type push_cmd
);

   logic [3:0]  wbytes;
   logic [31:0] wmask;
   logic [8:0]  cfg_end;
   logic [7:0]  cfg_bytes;
   vmblk_reg_type reg_id;

   // A transaction is taken whenever the queue has room.
   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   // Byte lanes of a register access, at most one word.
   always_comb begin
      if (req_payload.access_bytes >= 4'd4) begin
         wbytes = 4'hF;
      end else begin
         wbytes = 4'((5'd1 << req_payload.access_bytes[1:0]) - 5'd1);
      end
      wmask = {{8{wbytes[3]}}, {8{wbytes[2]}}, {8{wbytes[1]}}, {8{wbytes[0]}}};
   end

   // Byte lanes of a config space read; a read that runs past the end gives zero.
   always_comb begin
      cfg_end = {1'b0, req_payload.address[7:0]} + {5'd0, req_payload.access_bytes};
      if (cfg_end > CFG_SPACE_BYTES) begin
         cfg_bytes = 8'h00;
      end else if (req_payload.access_bytes >= 4'd8) begin
         cfg_bytes = 8'hFF;
      end else begin
         cfg_bytes = 8'((9'd1 << req_payload.access_bytes[2:0]) - 9'd1);
      end
   end

   // Register decode of the low offset.
   always_comb begin
      case (req_payload.address[7:0])
         OFS_MAGIC:          reg_id = REG_MAGIC;
         OFS_VERSION:        reg_id = REG_VERSION;
         OFS_DEVICE_ID:      reg_id = REG_DEVICE_ID;
         OFS_VENDOR:         reg_id = REG_VENDOR;
         OFS_HOST_FEAT:      reg_id = REG_HOST_FEAT;
         OFS_HOST_FEAT_SEL:  reg_id = REG_HOST_FEAT_SEL;
         OFS_GUEST_FEAT:     reg_id = REG_GUEST_FEAT;
         OFS_GUEST_FEAT_SEL: reg_id = REG_GUEST_FEAT_SEL;
         OFS_PAGE_SIZE:      reg_id = REG_PAGE_SIZE;
         OFS_QUEUE_SEL:      reg_id = REG_QUEUE_SEL;
         OFS_QUEUE_NUM_MAX:  reg_id = REG_QUEUE_NUM_MAX;
         OFS_QUEUE_NUM:      reg_id = REG_QUEUE_NUM;
         OFS_QUEUE_ALIGN:    reg_id = REG_QUEUE_ALIGN;
         OFS_QUEUE_READY:    reg_id = REG_QUEUE_READY;
         OFS_QUEUE_NOTIFY:   reg_id = REG_QUEUE_NOTIFY;
         OFS_INT_STATUS:     reg_id = REG_INT_STATUS;
         OFS_INT_ACK:        reg_id = REG_INT_ACK;
         OFS_STATUS:         reg_id = REG_STATUS;
         OFS_DESC_LO:        reg_id = REG_DESC_LO;
         OFS_DESC_HI:        reg_id = REG_DESC_HI;
         OFS_AVAIL_LO:       reg_id = REG_AVAIL_LO;
         OFS_AVAIL_HI:       reg_id = REG_AVAIL_HI;
         OFS_USED_LO:        reg_id = REG_USED_LO;
         OFS_USED_HI:        reg_id = REG_USED_HI;
         default:            reg_id = REG_NONE;
      endcase
   end

   // Build the command for the back end.
   always_comb begin
      push_cmd.reg_id     = reg_id;
      push_cmd.data       = req_payload.write_data & wmask;
      push_cmd.cfg_offset = req_payload.address[4:0];
      push_cmd.byte_en    = {4'h0, wbytes};
      case (req_payload.mode)
         MODE_READ: begin
            if (req_payload.address[8]) begin
               push_cmd.op      = OP_CFG_READ;
               push_cmd.byte_en = cfg_bytes;
            end else begin
               push_cmd.op = OP_REG_READ;
            end
         end
         MODE_WRITE: begin
            push_cmd.op = req_payload.address[8] ? OP_NONE : OP_REG_WRITE;
         end
         MODE_COMPLETE: begin
            push_cmd.op = req_payload.suppress_interrupt ? OP_NONE : OP_COMPLETE;
         end
         default: begin
            push_cmd.op = OP_NONE;
         end
      endcase
   end

endmodule

>>> rtl/core/vmblk_queue.sv
// Short command queue between the front and back ends.
// Depends on vmblk_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vmblk_queue
   import vmblk_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  vmblk_cmd_type   push_cmd,
   input  logic            pop,
   output logic            full,
   output vmblk_qstat_type qstat
);

   vmblk_cmd_type            entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   cnt_ff, cnt_in;

   assign full            = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign qstat.not_empty = (cnt_ff != '0);
   assign qstat.head      = entries_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `VM_ASSERT(a_queue_count_bound, cnt_ff <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue overfilled")
   `VM_ASSERT_NEXT(a_queue_push_fills, push && !pop, cnt_ff != '0, "push lost in queue")

endmodule

>>> rtl/core/vmblk_back.sv
// Back end: executes commands against the register file and holds the result.
// Depends on vmblk_pkg and assert_macros.svh; fed by vmblk_queue.
`include "assert_macros.svh"

module vmblk_back
   import vmblk_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  vmblk_cfg_type   cfg,
   input  vmblk_qstat_type qstat,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output vmblk_rsp_type   rsp_payload
);

   // Register file state.
   logic        host_ro_ff, host_ro_in;
   logic [31:0] host_sel_ff, host_sel_in;
   logic [63:0] guest_feat_ff, guest_feat_in;
   logic [31:0] guest_sel_ff, guest_sel_in;
   logic [31:0] page_size_ff, page_size_in;
   logic [31:0] queue_sel_ff, queue_sel_in;
   logic [15:0] queue_num_ff, queue_num_in;
   logic [31:0] queue_align_ff, queue_align_in;
   logic        queue_ready_ff, queue_ready_in;
   logic [63:0] desc_ff, desc_in;
   logic [63:0] avail_ff, avail_in;
   logic [63:0] used_ff, used_in;
   logic        irq_ff, irq_in;
   logic [31:0] status_ff, status_in;

   // Result register.
   logic          rsp_valid_ff, rsp_valid_in;
   vmblk_rsp_type rsp_ff, rsp_in;

   vmblk_cmd_type cmd;
   logic          exec;
   logic [63:0]   host_feat;
   logic [31:0]   reg_val;
   logic [63:0]   byte_mask;
   logic [255:0]  cfg_space;
   logic [255:0]  cfg_shifted;
   logic [63:0]   read_data;
   logic          start;
   logic          trig;

   assign cmd       = qstat.head;
   assign exec      = qstat.not_empty && (!rsp_valid_ff || rsp_ready);
   assign pop       = exec;
   assign host_feat = FEAT_VERSION1 | FEAT_BLK_SIZE | (host_ro_ff ? FEAT_RO : 64'h0);

   // Byte enables to bit mask.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         byte_mask[8*i +: 8] = {8{cmd.byte_en[i]}};
      end
   end

   // Register read mux.
   always_comb begin
      case (cmd.reg_id)
         REG_MAGIC:          reg_val = MAGIC_VALUE;
         REG_VERSION:        reg_val = VERSION_VALUE;
         REG_DEVICE_ID:      reg_val = cfg.device_present ? DEVICE_ID_BLK : 32'h0;
         REG_VENDOR:         reg_val = VENDOR_VALUE;
         REG_HOST_FEAT:      reg_val = (host_sel_ff == 32'h0) ? host_feat[31:0]
                                                                : host_feat[63:32];
         REG_HOST_FEAT_SEL:  reg_val = host_sel_ff;
         REG_GUEST_FEAT:     reg_val = (guest_sel_ff == 32'h0) ? guest_feat_ff[31:0]
                                                                 : guest_feat_ff[63:32];
         REG_GUEST_FEAT_SEL: reg_val = guest_sel_ff;
         REG_PAGE_SIZE:      reg_val = page_size_ff;
         REG_QUEUE_SEL:      reg_val = queue_sel_ff;
         REG_QUEUE_NUM_MAX:  reg_val = (queue_sel_ff == 32'h0) ? {16'h0, cfg.max_queue_size}
                                                                 : 32'h0;
         REG_QUEUE_NUM:      reg_val = {16'h0, queue_num_ff};
         REG_QUEUE_ALIGN:    reg_val = queue_align_ff;
         REG_QUEUE_READY:    reg_val = {31'h0, queue_ready_ff};
         REG_INT_STATUS:     reg_val = {31'h0, irq_ff};
         REG_STATUS:         reg_val = status_ff;
         REG_DESC_LO:        reg_val = desc_ff[31:0];
         REG_DESC_HI:        reg_val = desc_ff[63:32];
         REG_AVAIL_LO:       reg_val = avail_ff[31:0];
         REG_AVAIL_HI:       reg_val = avail_ff[63:32];
         REG_USED_LO:        reg_val = used_ff[31:0];
         REG_USED_HI:        reg_val = used_ff[63:32];
         default:            reg_val = 32'h0;
      endcase
   end

   // Config space: capacity in bytes 0..7, block size in bytes 20..21.
   always_comb begin
      cfg_space              = '0;
      cfg_space[63:0]        = {9'h0, cfg.capacity_sectors};
      cfg_space[175:160]     = SECTOR_BYTES;
      cfg_shifted            = cfg_space >> {cmd.cfg_offset, 3'b000};
   end

   // Command execution and next state.
   always_comb begin
      host_ro_in     = host_ro_ff;
      host_sel_in    = host_sel_ff;
      guest_feat_in  = guest_feat_ff;
      guest_sel_in   = guest_sel_ff;
      page_size_in   = page_size_ff;
      queue_sel_in   = queue_sel_ff;
      queue_num_in   = queue_num_ff;
      queue_align_in = queue_align_ff;
      queue_ready_in = queue_ready_ff;
      desc_in        = desc_ff;
      avail_in       = avail_ff;
      used_in        = used_ff;
      irq_in         = irq_ff;
      status_in      = status_ff;
      read_data      = 64'h0;
      start          = 1'b0;
      trig           = 1'b0;
      if (exec) begin
         case (cmd.op)
            OP_REG_READ: begin
               read_data = {32'h0, reg_val} & byte_mask;
            end
            OP_CFG_READ: begin
               read_data = cfg_shifted[63:0] & byte_mask;
            end
            OP_COMPLETE: begin
               irq_in = 1'b1;
               trig   = 1'b1;
            end
            OP_REG_WRITE: begin
               case (cmd.reg_id)
                  REG_HOST_FEAT_SEL:  host_sel_in  = cmd.data;
                  REG_GUEST_FEAT_SEL: guest_sel_in = cmd.data;
                  REG_GUEST_FEAT: begin
                     if (guest_sel_ff != 32'h0) begin
                        guest_feat_in[63:32] = cmd.data;
                     end else begin
                        guest_feat_in[31:0] = cmd.data;
                     end
                  end
                  REG_PAGE_SIZE:      page_size_in   = cmd.data;
                  REG_QUEUE_SEL:      queue_sel_in   = cmd.data;
                  REG_QUEUE_NUM:      queue_num_in   = cmd.data[15:0];
                  REG_QUEUE_ALIGN:    queue_align_in = cmd.data;
                  REG_QUEUE_READY:    queue_ready_in = (cmd.data != 32'h0);
                  REG_DESC_LO:        desc_in[31:0]   = cmd.data;
                  REG_DESC_HI:        desc_in[63:32]  = cmd.data;
                  REG_AVAIL_LO:       avail_in[31:0]  = cmd.data;
                  REG_AVAIL_HI:       avail_in[63:32] = cmd.data;
                  REG_USED_LO:        used_in[31:0]   = cmd.data;
                  REG_USED_HI:        used_in[63:32]  = cmd.data;
                  REG_QUEUE_NOTIFY: begin
                     start = (cmd.data == 32'h0) && queue_ready_ff && (queue_num_ff != 16'h0)
                             && (desc_ff != 64'h0) && (avail_ff != 64'h0)
                             && (used_ff != 64'h0);
                  end
                  REG_INT_ACK: begin
                     irq_in = irq_ff & !cmd.data[0];
                  end
                  REG_STATUS: begin
                     if (cmd.data == 32'h0) begin
                        // Device reset; configuration registers are kept.
                        host_ro_in     = cfg.read_only;
                        host_sel_in    = 32'h0;
                        guest_feat_in  = 64'h0;
                        guest_sel_in   = 32'h0;
                        page_size_in   = 32'h0;
                        queue_sel_in   = 32'h0;
                        queue_num_in   = 16'h0;
                        queue_align_in = 32'h0;
                        queue_ready_in = 1'b0;
                        desc_in        = 64'h0;
                        avail_in       = 64'h0;
                        used_in        = 64'h0;
                        irq_in         = 1'b0;
                        status_in      = 32'h0;
                     end else begin
                        status_in = cmd.data;
                        // Features-ok only sticks when guest features fit the host's.
                        if ((guest_feat_ff & ~host_feat) != 64'h0) begin
                           status_in[STATUS_FEAT_OK_BIT] = 1'b0;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // Result register: loads on execution, empties when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (exec) begin
         rsp_valid_in          = 1'b1;
         rsp_in.read_data      = read_data;
         rsp_in.queue_start    = start;
         rsp_in.irq_trigger    = trig;
         rsp_in.irq_pending    = irq_in;
         rsp_in.desc_address   = desc_in;
         rsp_in.avail_address  = avail_in;
         rsp_in.used_address   = used_in;
         rsp_in.queue_size     = queue_num_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         host_ro_ff     <= 1'b0;
         host_sel_ff    <= 32'h0;
         guest_feat_ff  <= 64'h0;
         guest_sel_ff   <= 32'h0;
         page_size_ff   <= 32'h0;
         queue_sel_ff   <= 32'h0;
         queue_num_ff   <= 16'h0;
         queue_align_ff <= 32'h0;
         queue_ready_ff <= 1'b0;
         desc_ff        <= 64'h0;
         avail_ff       <= 64'h0;
         used_ff        <= 64'h0;
         irq_ff         <= 1'b0;
         status_ff      <= 32'h0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         host_ro_ff     <= host_ro_in;
         host_sel_ff    <= host_sel_in;
         guest_feat_ff  <= guest_feat_in;
         guest_sel_ff   <= guest_sel_in;
         page_size_ff   <= page_size_in;
         queue_sel_ff   <= queue_sel_in;
         queue_num_ff   <= queue_num_in;
         queue_align_ff <= queue_align_in;
         queue_ready_ff <= queue_ready_in;
         desc_ff        <= desc_in;
         avail_ff       <= avail_in;
         used_ff        <= used_in;
         irq_ff         <= irq_in;
         status_ff      <= status_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `VM_ASSERT(a_trig_sets_pending, !(rsp_valid_ff && rsp_ff.irq_trigger) || rsp_ff.irq_pending, "interrupt raised but not pending")
   `VM_ASSERT(a_start_trig_exclusive, !(rsp_valid_ff && rsp_ff.queue_start && rsp_ff.irq_trigger), "start and interrupt from one transaction")
   `VM_ASSERT_NEXT(a_status_zero_resets, exec && (cmd.op == OP_REG_WRITE) && (cmd.reg_id == REG_STATUS) && (cmd.data == 32'h0), (status_ff == 32'h0) && !irq_ff && !queue_ready_ff, "device reset incomplete")

endmodule

>>> rtl/core/virtio_mmio_block_register_file_top.sv
// Top level of the virtio-mmio block register file: front end, command queue,
// back end and the configuration registers. Depends on vmblk_pkg and the vmblk_* modules.
//
//   Channel   Direction  Handshake              Payload
//   req       in         req_valid/req_ready    vmblk_req_type
//   rsp       out        rsp_valid/rsp_ready    vmblk_rsp_type
//   csr       in/out     psel/penable/pready    paddr, pwdata, prdata (64 bit)
//
// One transaction per cycle sustained while rsp_ready stays high; a transaction is
// registered in the command queue, then in the result register of the back end.
// The two-entry command queue lets requests keep flowing while a result waits.
// req_ready drops only when the queue is full behind a stalled response.
// Synchronous reset; no clearing pass, the block is ready the cycle after reset.
module virtio_mmio_block_register_file_top
   import vmblk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  vmblk_req_type         req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output vmblk_rsp_type         rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic            device_present_ff, device_present_in;
   logic            read_only_ff, read_only_in;
   logic [54:0]     capacity_ff, capacity_in;
   logic [15:0]     max_queue_ff, max_queue_in;
   vmblk_csr_type   csr_index;
   vmblk_cfg_type   cfg;
   logic            csr_write;
   logic            push;
   vmblk_cmd_type   push_cmd;
   logic            queue_full;
   logic            pop;
   vmblk_qstat_type qstat;

   // Configuration port: eight-byte registers, always ready.
   assign pready    = 1'b1;
   assign csr_index = vmblk_csr_type'(paddr[4:3]);
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      device_present_in = device_present_ff;
      read_only_in      = read_only_ff;
      capacity_in       = capacity_ff;
      max_queue_in      = max_queue_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_DEVICE_PRESENT: device_present_in = pwdata[0];
            CSR_READ_ONLY:      read_only_in      = pwdata[0];
            CSR_CAPACITY:       capacity_in       = pwdata[54:0];
            CSR_MAX_QUEUE:      max_queue_in      = pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Read back of the configuration registers.
   always_comb begin
      case (csr_index)
         CSR_DEVICE_PRESENT: prdata = {63'h0, device_present_ff};
         CSR_READ_ONLY:      prdata = {63'h0, read_only_ff};
         CSR_CAPACITY:       prdata = {9'h0, capacity_ff};
         CSR_MAX_QUEUE:      prdata = {48'h0, max_queue_ff};
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_present_ff <= 1'b0;
         read_only_ff      <= 1'b0;
         capacity_ff       <= 55'h0;
         max_queue_ff      <= MAX_QUEUE_RESET;
      end else begin
         device_present_ff <= device_present_in;
         read_only_ff      <= read_only_in;
         capacity_ff       <= capacity_in;
         max_queue_ff      <= max_queue_in;
      end
   end

   assign cfg.device_present   = device_present_ff;
   assign cfg.read_only        = read_only_ff;
   assign cfg.capacity_sectors = capacity_ff;
   assign cfg.max_queue_size   = max_queue_ff;

   vmblk_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   vmblk_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (queue_full),
      .qstat    (qstat)
   );

   vmblk_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .qstat       (qstat),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
